[hdl/fpo_pkg.sv]
package fpo_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_CHANNEL_COUNT = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_WING_COUNT    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_BLOCK_COUNT   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_BUDDY_SIZE    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SPREAD        = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_START         = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_INVERT        = 3'd6;

  localparam int unsigned CfgDataW = 24;
  localparam int unsigned CountW   = 10;
  localparam int unsigned IndexW   = 9;
  localparam int unsigned OffsetW  = 24;

  // Iterative divider for the derived wing constants
  localparam int unsigned SeqNumW = 12;
  localparam int unsigned SeqDenW = 11;
  localparam logic [3:0]  SeqLastStep = 4'd12;

  typedef enum logic [2:0] {
    S_IDLE,
    S_T,
    S_CEIL,
    S_RND,
    S_FLR
  } seq_state_e;

endpackage

[hdl/fixture_phase_offset.sv]
// One item per cycle is sustained while results are taken and no wing constants are being derived.
// The depth is set by three bit-per-stage division pipelines (19, 19 and 35 stages)
// plus the index division (9 stages) and the multiply, rounding and output stages.
// After reset the derived wing constants hold their reset values and items are taken at once.
// Each configuration write reruns a shared iterative divider, with in_ready_o low until it finishes.
// The whole pipeline advances together whenever the output register is free or taken.
module fixture_phase_offset #(
  parameter int unsigned MAX_CHANNELS = 512
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [fpo_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [fpo_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [fpo_pkg::IndexW-1:0]      channel_index_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [fpo_pkg::OffsetW-1:0] phase_offset_o,
  output logic                            is_winged_o,
  output logic                            is_centered_o,
  output logic                            size_error_o
);
  import fpo_pkg::*;

  // Configuration registers
  logic [CountW-1:0]         chan_q, wing_q, blk_q, buddy_q;
  logic signed [OffsetW-1:0] spread_q, start_q;
  logic                      invert_q;

  // Derived wing constants
  logic [CountW-1:0] t_q, ceilw_q, rnd_q, flr_q, remtw_q;
  logic              err_q;

  // Sequencer
  seq_state_e         state_q, state_d;
  logic [3:0]         cnt_q;
  logic [SeqNumW-1:0] dnum_q;
  logic [SeqDenW-1:0] drem_q, dden_q;
  logic               seq_load, seq_step, seq_done;
  logic [SeqNumW-1:0] op_num;
  logic [SeqDenW-1:0] op_den;
  logic [SeqDenW:0]   dsh, ddiff;
  logic               dge;
  logic [SeqNumW-1:0] dquo_n;
  logic [SeqDenW-1:0] drem_n;
  logic [SeqDenW-1:0] n_clamp;
  logic               cfg_xfer;

  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q   <= CountW'(1);
      wing_q   <= CountW'(1);
      blk_q    <= CountW'(1);
      buddy_q  <= CountW'(1);
      spread_q <= OffsetW'(65536);
      start_q  <= '0;
      invert_q <= 1'b0;
    end else if (cfg_xfer) begin
      unique case (cfg_index_i)
        CFG_CHANNEL_COUNT: chan_q   <= cfg_data_i[CountW-1:0];
        CFG_WING_COUNT:    wing_q   <= cfg_data_i[CountW-1:0];
        CFG_BLOCK_COUNT:   blk_q    <= cfg_data_i[CountW-1:0];
        CFG_BUDDY_SIZE:    buddy_q  <= cfg_data_i[CountW-1:0];
        CFG_SPREAD:        spread_q <= cfg_data_i;
        CFG_START:         start_q  <= cfg_data_i;
        CFG_INVERT:        invert_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign n_clamp = (32'(chan_q) > MAX_CHANNELS) ? SeqDenW'(MAX_CHANNELS)
                                                : SeqDenW'(chan_q);

  // Next state of the constant sequencer
  always_comb begin
    state_d = state_q;
    if (cfg_xfer) begin
      state_d = S_T;
    end else begin
      unique case (state_q)
        S_IDLE: state_d = S_IDLE;
        S_T:    if (seq_done) state_d = S_CEIL;
        S_CEIL: if (seq_done) state_d = S_RND;
        S_RND:  if (seq_done) state_d = S_FLR;
        S_FLR:  if (seq_done) state_d = S_IDLE;
        default: state_d = S_IDLE;
      endcase
    end
  end

  // Sequencer outputs: operand selection and step control
  always_comb begin
    op_num = '0;
    op_den = '0;
    unique case (state_q)
      S_T: begin
        op_num = SeqNumW'(n_clamp) + SeqNumW'(buddy_q) - SeqNumW'(1);
        op_den = SeqDenW'(buddy_q);
      end
      S_CEIL: begin
        op_num = SeqNumW'(t_q) + SeqNumW'(wing_q) - SeqNumW'(1);
        op_den = SeqDenW'(wing_q);
      end
      S_RND: begin
        op_num = {1'b0, t_q, 1'b0} + SeqNumW'(wing_q);
        op_den = {wing_q, 1'b0};
      end
      S_FLR: begin
        op_num = SeqNumW'(t_q);
        op_den = SeqDenW'(wing_q);
      end
      default: ;
    endcase
    seq_load = (state_q != S_IDLE) && (cnt_q == '0);
    seq_step = (state_q != S_IDLE) && (cnt_q != '0);
    seq_done = seq_step && (cnt_q == SeqLastStep);
  end

  assign dsh    = {drem_q, dnum_q[SeqNumW-1]};
  assign dge    = dsh >= {1'b0, dden_q};
  assign ddiff  = dsh - {1'b0, dden_q};
  assign dquo_n = {dnum_q[SeqNumW-2:0], dge};
  assign drem_n = dge ? ddiff[SeqDenW-1:0] : dsh[SeqDenW-1:0];

  // Advance sequencer and capture constants
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      t_q     <= CountW'(1);
      ceilw_q <= CountW'(1);
      rnd_q   <= CountW'(1);
      flr_q   <= CountW'(1);
      remtw_q <= '0;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_xfer || seq_done) begin
        cnt_q <= '0;
      end else if (state_q != S_IDLE) begin
        cnt_q <= cnt_q + 4'd1;
      end
      if (seq_done && !cfg_xfer) begin
        unique case (state_q)
          S_T:    t_q     <= dquo_n[CountW-1:0];
          S_CEIL: ceilw_q <= dquo_n[CountW-1:0];
          S_RND:  rnd_q   <= dquo_n[CountW-1:0];
          S_FLR: begin
            flr_q   <= dquo_n[CountW-1:0];
            remtw_q <= drem_n[CountW-1:0];
            err_q   <= (wing_q == '0) || (buddy_q == '0) || (rnd_q == '0);
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_load) begin
      dnum_q <= op_num;
      drem_q <= '0;
      dden_q <= op_den;
    end else if (seq_step) begin
      dnum_q <= dquo_n;
      drem_q <= drem_n;
    end
  end

  // ---------------------------------------------------------------------
  // Item pipeline
  // ---------------------------------------------------------------------
  logic en;
  logic out_valid_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en && (state_q == S_IDLE);

  // Group index r = index / buddy_size
  logic              d1_vld;
  logic [IndexW-1:0] d1_quo;
  logic [CountW-1:0] d1_rem;
  logic              d1_side;

  fpo_div_pipe #(.NUM_W(IndexW), .DEN_W(CountW), .SIDE_W(1)) u_div_grp (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(in_valid_i && in_ready_o),
    .num_i(channel_index_i), .den_i(buddy_q), .side_i(1'b0),
    .valid_o(d1_vld), .quo_o(d1_quo), .rem_o(d1_rem), .side_o(d1_side)
  );

  // Multiply group index by wing count
  logic                     m1_vld_q;
  logic [IndexW+CountW-1:0] m1_prod_q;
  logic [IndexW-1:0]        m1_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m1_vld_q <= 1'b0;
    else if (en) m1_vld_q <= d1_vld;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_prod_q <= (IndexW+CountW)'(d1_quo) * (IndexW+CountW)'(wing_q);
      m1_r_q    <= d1_quo;
    end
  end

  // Wing number (r*w)/t and position r mod rnd in parallel
  logic                     d2_vld, d3_vld;
  logic [IndexW+CountW-1:0] d2_quo, d3_quo;
  logic [CountW-1:0]        d2_rem, d3_rem;
  logic [IndexW-1:0]        d2_r;
  logic                     d3_side;

  fpo_div_pipe #(.NUM_W(IndexW+CountW), .DEN_W(CountW), .SIDE_W(IndexW)) u_div_wing (
    .clk_i, .rst_ni, .en_i(en), .valid_i(m1_vld_q),
    .num_i(m1_prod_q), .den_i(t_q), .side_i(m1_r_q),
    .valid_o(d2_vld), .quo_o(d2_quo), .rem_o(d2_rem), .side_o(d2_r)
  );

  fpo_div_pipe #(.NUM_W(IndexW+CountW), .DEN_W(CountW), .SIDE_W(1)) u_div_mirr (
    .clk_i, .rst_ni, .en_i(en), .valid_i(m1_vld_q),
    .num_i((IndexW+CountW)'(m1_r_q)), .den_i(rnd_q), .side_i(1'b0),
    .valid_o(d3_vld), .quo_o(d3_quo), .rem_o(d3_rem), .side_o(d3_side)
  );

  // Mirror odd wings, flag the centre of a fractional wing
  logic                     odd_wing;
  logic signed [CountW+1:0] mq, mq_adj;
  logic [IndexW-1:0]        r_pos;
  logic                     centred;
  logic                     p_vld_q, p_wing_q, p_cent_q;
  logic [IndexW-1:0]        p_r_q;

  always_comb begin
    odd_wing = d2_quo[0];
    mq       = $signed({2'b00, flr_q}) - $signed((CountW+2)'(1))
             - $signed({2'b00, d3_rem});
    mq_adj   = mq + $signed((CountW+2)'((mq < 0) && (remtw_q != '0)));
    r_pos    = odd_wing ? mq_adj[IndexW-1:0] : d2_r;
    centred  = !odd_wing && (CountW'(d2_r) == flr_q) && (remtw_q != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p_vld_q <= 1'b0;
    else if (en) p_vld_q <= d2_vld;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_r_q    <= r_pos;
      p_wing_q <= odd_wing;
      p_cent_q <= centred;
    end
  end

  // Multiply position by block count
  logic                     m2_vld_q;
  logic [IndexW+CountW-1:0] m2_prod_q;
  logic [1:0]               m2_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m2_vld_q <= 1'b0;
    else if (en) m2_vld_q <= p_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m2_prod_q  <= (IndexW+CountW)'(p_r_q) * (IndexW+CountW)'(blk_q);
      m2_flags_q <= {p_wing_q, p_cent_q};
    end
  end

  // Wrap within the rounded wing size
  logic                     d4_vld;
  logic [IndexW+CountW-1:0] d4_quo;
  logic [CountW-1:0]        d4_rem;
  logic [1:0]               d4_flags;

  fpo_div_pipe #(.NUM_W(IndexW+CountW), .DEN_W(CountW), .SIDE_W(2)) u_div_wrap (
    .clk_i, .rst_ni, .en_i(en), .valid_i(m2_vld_q),
    .num_i(m2_prod_q), .den_i(rnd_q), .side_i(m2_flags_q),
    .valid_o(d4_vld), .quo_o(d4_quo), .rem_o(d4_rem), .side_o(d4_flags)
  );

  // Scale by spread
  localparam int unsigned ProdW = CountW + OffsetW + 1;
  logic                    m3_vld_q;
  logic signed [ProdW-1:0] m3_a_q;
  logic [1:0]              m3_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m3_vld_q <= 1'b0;
    else if (en) m3_vld_q <= d4_vld;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m3_a_q     <= $signed({1'b0, d4_rem}) * spread_q;
      m3_flags_q <= d4_flags;
    end
  end

  // Take magnitude and form the rounding numerator 2|a| + L
  logic [ProdW-1:0] mag;
  logic             s_vld_q, s_sgn_q;
  logic [ProdW-1:0] s_num_q;
  logic [1:0]       s_flags_q;

  assign mag = m3_a_q[ProdW-1] ? ProdW'(-m3_a_q) : ProdW'(m3_a_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s_vld_q <= 1'b0;
    else if (en) s_vld_q <= m3_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_sgn_q   <= m3_a_q[ProdW-1];
      s_num_q   <= {mag[ProdW-2:0], 1'b0} + ProdW'(ceilw_q);
      s_flags_q <= m3_flags_q;
    end
  end

  // Divide by 2L for round half away from zero
  logic              d5_vld;
  logic [ProdW-1:0]  d5_quo;
  logic [CountW:0]   d5_rem;
  logic [2:0]        d5_side;

  fpo_div_pipe #(.NUM_W(ProdW), .DEN_W(CountW+1), .SIDE_W(3)) u_div_round (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s_vld_q),
    .num_i(s_num_q), .den_i({ceilw_q, 1'b0}), .side_i({s_sgn_q, s_flags_q}),
    .valid_o(d5_vld), .quo_o(d5_quo), .rem_o(d5_rem), .side_o(d5_side)
  );

  // Add start, invert, negate and saturate
  localparam int unsigned FinW = ProdW + 3;
  localparam logic signed [FinW-1:0] SatHi = FinW'(8388607);
  localparam logic signed [FinW-1:0] SatLo = -FinW'(8388608);
  logic signed [FinW-1:0] sq, off, off_inv, neg;
  logic signed [OffsetW-1:0] sat;

  always_comb begin
    sq      = $signed({3'b000, d5_quo});
    if (d5_side[2]) sq = -sq;
    off     = sq + FinW'(start_q);
    off_inv = invert_q ? (FinW'(65536) - off) : off;
    neg     = -off_inv;
    if (neg > SatHi)      sat = SatHi[OffsetW-1:0];
    else if (neg < SatLo) sat = SatLo[OffsetW-1:0];
    else                  sat = neg[OffsetW-1:0];
  end

  // Output register
  logic signed [OffsetW-1:0] phase_q;
  logic                      wing_o_q, cent_o_q, err_o_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= d5_vld;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      phase_q  <= err_q ? '0 : sat;
      wing_o_q <= !err_q && d5_side[1];
      cent_o_q <= !err_q && d5_side[0];
      err_o_q  <= err_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign phase_offset_o = phase_q;
  assign is_winged_o    = wing_o_q;
  assign is_centered_o  = cent_o_q;
  assign size_error_o   = err_o_q;

  // Checks
  a_busy_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o)
    else $error("item taken while wing constants are being derived");

  a_cfg_then_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_xfer |=> !in_ready_o)
    else $error("input ready straight after a configuration transfer");

  a_error_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && size_error_o) |->
      (phase_offset_o == '0) && !is_winged_o && !is_centered_o)
    else $error("size error result carries non-zero fields");

  a_wing_centre_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(is_winged_o && is_centered_o))
    else $error("result both mirrored and centred");

endmodule

[hdl/fpo_div_pipe.sv]
module fpo_div_pipe #(
  parameter int unsigned NUM_W  = 9,
  parameter int unsigned DEN_W  = 10,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [NUM_W-1:0]  quo_o,
  output logic [DEN_W-1:0]  rem_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              vld  [0:NUM_W];
  logic [NUM_W-1:0]  sr   [0:NUM_W];
  logic [DEN_W-1:0]  rem  [0:NUM_W];
  logic [SIDE_W-1:0] sd   [0:NUM_W];

  assign vld[0] = valid_i;
  assign sr[0]  = num_i;
  assign rem[0] = '0;
  assign sd[0]  = side_i;

  // One quotient bit per stage; numerator shifts out as quotient shifts in
  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic [DEN_W:0] sh;
    logic [DEN_W:0] diff;
    logic           ge;

    assign sh   = {rem[s], sr[s][NUM_W-1]};
    assign ge   = sh >= {1'b0, den_i};
    assign diff = sh - {1'b0, den_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[s+1] <= 1'b0;
      end else if (en_i) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sr[s+1]  <= {sr[s][NUM_W-2:0], ge};
        rem[s+1] <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
        sd[s+1]  <= sd[s];
      end
    end
  end

  assign valid_o = vld[NUM_W];
  assign quo_o   = sr[NUM_W];
  assign rem_o   = rem[NUM_W];
  assign side_o  = sd[NUM_W];

endmodule
